// File: rtl/core/lbsp_pkg.sv
// ============================================================================
// lbsp_pkg: shared constants for the logo block scatter position pipeline
// Holds the grid, velocity, geometry and mixer constants, the derived widths and the stream widths.
// ============================================================================
package lbsp_pkg;

    // Grid and motion parameters.
    localparam int unsigned GRID_COLUMNS   = 31;
    localparam int unsigned VELOCITY_RANGE = 204800;

    // Geometry of the logo on screen and in the source image.
    localparam int unsigned ORIGIN_X = 107;
    localparam int unsigned ORIGIN_Y = 76;
    localparam int unsigned STEP_X   = 6;
    localparam int unsigned STEP_Y   = 2;

    // Hash constants.
    localparam logic [31:0] SEED_RESET = 32'h4443_5331;
    localparam logic [31:0] KEY_OFFSET = 32'h0001_0000;
    localparam logic [31:0] KEY_MULT   = 32'h9E37_79B9;
    localparam logic [31:0] MIX_MULT1  = 32'h7FEB_352D;
    localparam logic [31:0] MIX_MULT2  = 32'h846C_A68B;

    // Derived widths.
    localparam int unsigned SPAN   = 2 * VELOCITY_RANGE + 1;
    localparam int unsigned SPAN_W = $clog2(SPAN + 1);
    localparam int unsigned V_W    = $clog2(VELOCITY_RANGE + 1) + 1;
    localparam int unsigned A_W    = (V_W > 8) ? V_W - 6 : 2;
    localparam int unsigned NV_W   = V_W + 17;
    localparam int unsigned AT_W   = A_W + 33;
    localparam int unsigned POS_W  = A_W + 35;
    localparam int unsigned IDX_W  = $clog2(63 * GRID_COLUMNS + 32);

    // Pipeline depth and stream widths.
    localparam int unsigned NUM_STAGES = 7;
    localparam int unsigned S_TDATA_W  = 32;
    localparam int unsigned M_TDATA_W  = 40;

    typedef logic signed [V_W-1:0]   t_velocity;
    typedef logic signed [A_W-1:0]   t_accel;
    typedef logic signed [POS_W-1:0] t_position;

endpackage

// File: rtl/core/logo_block_scatter_position_top.sv
// ============================================================================
// logo_block_scatter_position_top: scatter effect position of one logo block
// Hashes seed and block index into a velocity and evaluates the closed-form
// position after a number of frame ticks, floored and saturated to a pixel.
// ============================================================================
// Usage:
//   The slave stream takes one transaction per block: column, row and frame
//   tick. The master stream returns one transaction per input in order:
//   destination x and y and source x and y of that block.
//   The configuration channel writes the effect seed; it is always ready and
//   should be written only while no transaction is in flight.
//   An accepted input reaches the master side through seven register stages
//   (index hash multiply, two mixer multiplies, velocity scaling, n*v,
//   a*n*(n+1)/2, final sum and clamp).
//   Throughput is one transaction per cycle while the receiver accepts results.
//   When the receiver stalls, the result holds in the output register while
//   the stages behind it keep filling empty slots; s_axis_tready drops only
//   once all seven stages hold data.
//   Reset clears all stage valid bits and loads the default seed.
// ============================================================================
module logo_block_scatter_position_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration: effect seed.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [31:0]                      i_cfg_data,
    // Fields from bit 0 up: block_column[4:0], block_row[10:5],
    // frame_tick[26:11], zero fill.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lbsp_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // Fields from bit 0 up: dest_x[15:0], dest_y[23:16], source_x[31:24],
    // source_y[38:32], zero fill.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lbsp_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int unsigned NS = lbsp_pkg::NUM_STAGES;

    // ------------------------------------------------------------------
    // Control: valid bits and per-stage advance chain.
    // ------------------------------------------------------------------
    logic [31:0]   r_seed;
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] w_adv;

    always_comb begin
        w_adv[NS-1] = ~r_vld[NS-1] | m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_adv[k] = ~r_vld[k] | w_adv[k+1];
        end
    end

    assign n_vld = {r_vld[NS-2:0], s_axis_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_seed <= lbsp_pkg::SEED_RESET;
        end else begin
            r_vld <= (w_adv & n_vld) | (~w_adv & r_vld);
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = w_adv[0];
    assign m_axis_tvalid = r_vld[NS-1];

    // ------------------------------------------------------------------
    // Stage 0: block index, key multiply, seed mix and n*(n+1)/2.
    // ------------------------------------------------------------------
    logic [4:0]                  n_col;
    logic [5:0]                  n_row;
    logic [15:0]                 n_n;
    logic [lbsp_pkg::IDX_W-1:0]  n_index;
    logic [31:0]                 n_key;
    logic [31:0]                 n0_h;
    logic [16:0]                 n_n1;
    logic [32:0]                 n_tri2;

    assign n_col   = s_axis_tdata[4:0];
    assign n_row   = s_axis_tdata[10:5];
    assign n_n     = s_axis_tdata[26:11];
    assign n_index = lbsp_pkg::IDX_W'(n_row) * lbsp_pkg::IDX_W'(lbsp_pkg::GRID_COLUMNS)
                   + lbsp_pkg::IDX_W'(n_col);
    assign n_key   = lbsp_pkg::KEY_OFFSET + 32'(n_index);
    assign n0_h    = r_seed ^ 32'(n_key * lbsp_pkg::KEY_MULT);
    assign n_n1    = {1'b0, n_n} + 17'd1;
    assign n_tri2  = 33'(n_n) * 33'(n_n1);

    logic [31:0] r0_h, r0_tri;
    logic [4:0]  r0_col;
    logic [5:0]  r0_row;
    logic [15:0] r0_n;

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r0_h   <= n0_h;
            r0_tri <= n_tri2[32:1];
            r0_col <= n_col;
            r0_row <= n_row;
            r0_n   <= n_n;
        end
    end

    // ------------------------------------------------------------------
    // Stages 1 and 2: xorshift-multiply mixer rounds.
    // ------------------------------------------------------------------
    logic [31:0] n1_x, n2_x;
    logic [31:0] r1_m, r1_tri;
    logic [4:0]  r1_col;
    logic [5:0]  r1_row;
    logic [15:0] r1_n;
    logic [31:0] r2_m, r2_tri;
    logic [4:0]  r2_col;
    logic [5:0]  r2_row;
    logic [15:0] r2_n;

    assign n1_x = r0_h ^ (r0_h >> 16);
    assign n2_x = r1_m ^ (r1_m >> 15);

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_m   <= 32'(n1_x * lbsp_pkg::MIX_MULT1);
            r1_tri <= r0_tri;
            r1_col <= r0_col;
            r1_row <= r0_row;
            r1_n   <= r0_n;
        end
        if (w_adv[2]) begin
            r2_m   <= 32'(n2_x * lbsp_pkg::MIX_MULT2);
            r2_tri <= r1_tri;
            r2_col <= r1_col;
            r2_row <= r1_row;
            r2_n   <= r1_n;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: scale the hash to a signed velocity.
    // ------------------------------------------------------------------
    localparam int unsigned SC_W = 32 + lbsp_pkg::SPAN_W;

    logic [31:0]                    n3_r;
    logic [SC_W-1:0]                n3_prod;
    logic [lbsp_pkg::SPAN_W-1:0]    n3_scaled;
    lbsp_pkg::t_velocity            n3_v;

    assign n3_r      = r2_m ^ (r2_m >> 16);
    assign n3_prod   = SC_W'(n3_r) * SC_W'(lbsp_pkg::SPAN);
    assign n3_scaled = n3_prod[32 +: lbsp_pkg::SPAN_W];
    assign n3_v      = $signed(lbsp_pkg::V_W'(n3_scaled)
                     - lbsp_pkg::V_W'(lbsp_pkg::VELOCITY_RANGE));

    lbsp_pkg::t_velocity r3_v;
    logic [31:0]         r3_tri;
    logic [4:0]          r3_col;
    logic [5:0]          r3_row;
    logic [15:0]         r3_n;

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r3_v   <= n3_v;
            r3_tri <= r2_tri;
            r3_col <= r2_col;
            r3_row <= r2_row;
            r3_n   <= r2_n;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: n*v and the acceleration a = -floor(v / 128).
    // ------------------------------------------------------------------
    logic signed [16:0]                 n4_ns;
    logic signed [lbsp_pkg::NV_W-1:0]   n4_nv;
    lbsp_pkg::t_velocity                n4_sh;
    lbsp_pkg::t_velocity                n4_neg;

    assign n4_ns  = $signed({1'b0, r3_n});
    assign n4_nv  = lbsp_pkg::NV_W'(n4_ns) * lbsp_pkg::NV_W'(r3_v);
    assign n4_sh  = r3_v >>> 7;
    assign n4_neg = -n4_sh;

    logic signed [lbsp_pkg::NV_W-1:0] r4_nv;
    lbsp_pkg::t_accel                 r4_a;
    logic [31:0]                      r4_tri;
    logic [4:0]                       r4_col;
    logic [5:0]                       r4_row;

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r4_nv  <= n4_nv;
            r4_a   <= $signed(n4_neg[lbsp_pkg::A_W-1:0]);
            r4_tri <= r3_tri;
            r4_col <= r3_col;
            r4_row <= r3_row;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: a*n*(n+1)/2 and the start position plus n*v.
    // ------------------------------------------------------------------
    logic signed [32:0]                 n5_tri;
    logic signed [lbsp_pkg::AT_W-1:0]   n5_at;
    logic [9:0]                         n5_x0px;
    lbsp_pkg::t_position                n5_x0;

    assign n5_tri  = $signed({1'b0, r4_tri});
    assign n5_at   = lbsp_pkg::AT_W'(r4_a) * lbsp_pkg::AT_W'(n5_tri);
    assign n5_x0px = 10'(lbsp_pkg::ORIGIN_X) + 10'(r4_col) * 10'(lbsp_pkg::STEP_X);
    assign n5_x0   = $signed(lbsp_pkg::POS_W'({n5_x0px, 16'h0000}));

    logic signed [lbsp_pkg::AT_W-1:0] r5_at;
    lbsp_pkg::t_position              r5_base;
    logic [4:0]                       r5_col;
    logic [5:0]                       r5_row;

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r5_at   <= n5_at;
            r5_base <= n5_x0 + lbsp_pkg::POS_W'(r4_nv);
            r5_col  <= r4_col;
            r5_row  <= r4_row;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: final sum, floor to a pixel, clamp, and the output register.
    // ------------------------------------------------------------------
    lbsp_pkg::t_position            n6_pos;
    logic [lbsp_pkg::POS_W-32:0]    n6_upper;
    logic                           n6_fits;
    logic [15:0]                    n6_dest_x;

    assign n6_pos   = r5_base + lbsp_pkg::POS_W'(r5_at);
    // The floored pixel fits 16 bits when bit 31 and all above agree.
    assign n6_upper = n6_pos[lbsp_pkg::POS_W-1:31];
    assign n6_fits  = (&n6_upper) | ~(|n6_upper);

    always_comb begin
        if (n6_fits) begin
            n6_dest_x = n6_pos[31:16];
        end else if (n6_pos[lbsp_pkg::POS_W-1]) begin
            n6_dest_x = 16'h8000;
        end else begin
            n6_dest_x = 16'h7FFF;
        end
    end

    logic [15:0] r6_dest_x;
    logic [7:0]  r6_dest_y;
    logic [7:0]  r6_source_x;
    logic [6:0]  r6_source_y;

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r6_dest_x   <= n6_dest_x;
            r6_dest_y   <= 8'(lbsp_pkg::ORIGIN_Y) + 8'(r5_row) * 8'(lbsp_pkg::STEP_Y);
            r6_source_x <= 8'(r5_col) * 8'(lbsp_pkg::STEP_X);
            r6_source_y <= 7'(r5_row) * 7'(lbsp_pkg::STEP_Y);
        end
    end

    assign m_axis_tdata = {1'b0, r6_source_y, r6_source_x, r6_dest_y, r6_dest_x};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Every accepted transaction occupies exactly one stage until delivered.
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        ($countones(r_vld) + int'($past(m_axis_tvalid && m_axis_tready))
         == $past($countones(r_vld)) + int'($past(s_axis_tvalid && s_axis_tready))))
        else $error("pipeline occupancy does not match accepted and delivered transactions");

    // A blocked first stage keeps its item.
    a_stage0_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && !w_adv[0]) |=> (r_vld[0] && $stable(r0_h) && $stable(r0_n)))
        else $error("first stage changed while blocked");

    // With the output register empty, the input side must be open.
    a_ready_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NS-1] |-> s_axis_tready)
        else $error("input blocked although the output register is empty");

endmodule
